// ----- hdl/klerp_pkg.sv -----
`default_nettype none
package klerp_pkg;

  localparam int CNT_W    = 7;
  localparam int SLOT_W   = 6;
  localparam int SEG_W    = 6;
  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;

  // Command codes carried on cmd
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] tstamp;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } key_t;

  // Handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic go;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/klerp_store.sv -----
`default_nettype none
module klerp_store #(
  parameter int DEPTH = 64,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire klerp_pkg::key_t   wdata,
  input  wire logic [IDX_W-1:0]  raddr,
  output klerp_pkg::key_t        rdata
);
  import klerp_pkg::*;

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/klerp_div.sv -----
`default_nettype none
module klerp_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire klerp_pkg::unit_req_t           req,
  input  wire logic [klerp_pkg::WORD_W-1:0]   num,
  input  wire logic [klerp_pkg::WORD_W-1:0]   den,
  output klerp_pkg::unit_rsp_t                rsp,
  output logic [klerp_pkg::FRAC_W-1:0]        quot
);
  import klerp_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] den_q;
  logic [WORD_W:0]   shifted;
  logic              fits;

  // Restoring division, one quotient bit a cycle; num < den holds on entry
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rsp.done <= 1'b0;
      step     <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(FRAC_W - 1)) begin
          running  <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem   <= num;
      den_q <= den;
      quot  <= '0;
    end else if (running) begin
      rem  <= fits ? WORD_W'(shifted - {1'b0, den_q}) : shifted[WORD_W-1:0];
      quot <= {quot[FRAC_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/klerp_lerp.sv -----
`default_nettype none
module klerp_lerp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire klerp_pkg::unit_req_t           req,
  input  wire klerp_pkg::key_t                ka,
  input  wire klerp_pkg::key_t                kb,
  input  wire logic [klerp_pkg::FRAC_W-1:0]   frac,
  output klerp_pkg::unit_rsp_t                rsp,
  output logic [klerp_pkg::WORD_W-1:0]        res_x,
  output logic [klerp_pkg::WORD_W-1:0]        res_y,
  output logic [klerp_pkg::WORD_W-1:0]        res_z
);
  import klerp_pkg::*;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam int PROD_W = WORD_W + FRAC_W + 2;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_DIFF = 4'b0010,
    L_MUL  = 4'b0100,
    L_ADD  = 4'b1000
  } lstate_t;

  lstate_t                   state;
  logic [1:0]                comp;
  logic [WORD_W-1:0]         sa;
  logic [WORD_W-1:0]         sb;
  logic signed [WORD_W:0]    diff;
  logic signed [PROD_W-1:0]  prod;
  logic [WORD_W-1:0]         sum;

  always_comb begin
    case (comp)
      COMP_X: begin
        sa = ka.x;
        sb = kb.x;
      end
      COMP_Y: begin
        sa = ka.y;
        sb = kb.y;
      end
      COMP_Z: begin
        sa = ka.z;
        sb = kb.z;
      end
      default: begin
        sa = ka.x;
        sb = kb.x;
      end
    endcase
  end

  // Arithmetic shift right by the fraction width floors; keep the low word
  assign sum = sa + prod[FRAC_W +: WORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      comp     <= COMP_X;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (req.go) begin
            comp  <= COMP_X;
            state <= L_DIFF;
          end
        end
        L_DIFF: state <= L_MUL;
        L_MUL:  state <= L_ADD;
        L_ADD: begin
          if (comp == COMP_Z) begin
            rsp.done <= 1'b1;
            state    <= L_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            state <= L_DIFF;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == L_DIFF) begin
      diff <= $signed({sb[WORD_W-1], sb}) - $signed({sa[WORD_W-1], sa});
    end
    if (state == L_MUL) begin
      prod <= diff * $signed({1'b0, frac});
    end
    if (state == L_ADD) begin
      case (comp)
        COMP_X:  res_x <= sum;
        COMP_Y:  res_y <= sum;
        COMP_Z:  res_z <= sum;
        default: res_x <= sum;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/keyframe_track_lerp_sampler.sv -----
// Write transaction: stored at the accepting edge, busy stays low, no result.
// Sample transaction: busy while key 0 is read (a clamp before the first key or with one key
// in use ends there), then while the keys are scanned up to the last key in use, then while
// the serial divider and the shared lerp datapath run; done pulses once as busy falls.
// The receiver cannot stall.
// rst (synchronous) sets key_count to 1 and idles the sequencer; the store is not cleared.
`default_nettype none
module keyframe_track_lerp_sampler #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          cmd,
  input  wire logic [klerp_pkg::SLOT_W-1:0] key_slot,
  input  wire logic [31:0]   key_time,
  input  wire logic [31:0]   key_x,
  input  wire logic [31:0]   key_y,
  input  wire logic [31:0]   key_z,
  input  wire logic [31:0]   sample_time,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [6:0]    cfg_data,
  output logic               done,
  output logic [31:0]        out_x,
  output logic [31:0]        out_y,
  output logic [31:0]        out_z,
  output logic [5:0]         segment,
  output logic               clamped
);
  import klerp_pkg::*;

  localparam int IDX_W = $clog2(MAX_KEYS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_KEY0 = 5'b00010,
    S_SCAN = 5'b00100,
    S_DIV  = 5'b01000,
    S_LERP = 5'b10000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   key_count;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   last;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   seg;
  logic [WORD_W-1:0]  t_q;
  key_t               prev;
  key_t               nxt;
  logic [WORD_W-1:0]  k0_x;
  logic [WORD_W-1:0]  k0_y;
  logic [WORD_W-1:0]  k0_z;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  key_t               wdata;
  logic [IDX_W-1:0]   raddr;
  key_t               rdata;

  unit_req_t          div_req;
  unit_rsp_t          div_rsp;
  logic [FRAC_W-1:0]  frac;
  unit_req_t          lerp_req;
  unit_rsp_t          lerp_rsp;
  logic [WORD_W-1:0]  lx;
  logic [WORD_W-1:0]  ly;
  logic [WORD_W-1:0]  lz;
  logic               accept;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      key_count <= cfg_data;
    end
  end

  // Index of the last key in use: zero counts as one, saturate at the store depth
  always_comb begin
    if (key_count == '0) begin
      last_idx = '0;
    end else if (32'(key_count) > 32'(MAX_KEYS)) begin
      last_idx = IDX_W'(MAX_KEYS - 1);
    end else begin
      last_idx = IDX_W'(key_count - CNT_W'(1));
    end
  end

  assign we    = accept && (cmd == CMD_WRITE) && (32'(key_slot) < 32'(MAX_KEYS));
  assign waddr = IDX_W'(key_slot);
  assign wdata = '{tstamp: key_time, x: key_x, y: key_y, z: key_z};

  always_comb begin
    case (state)
      S_KEY0:  raddr = IDX_W'(1);
      S_SCAN:  raddr = idx + IDX_W'(1);
      default: raddr = '0;
    endcase
  end

  klerp_store #(
    .DEPTH (MAX_KEYS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  klerp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (t_q - prev.tstamp),
    .den  (nxt.tstamp - prev.tstamp),
    .rsp  (div_rsp),
    .quot (frac)
  );

  klerp_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .req   (lerp_req),
    .ka    (prev),
    .kb    (nxt),
    .frac  (frac),
    .rsp   (lerp_rsp),
    .res_x (lx),
    .res_y (ly),
    .res_z (lz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      div_req.go  <= 1'b0;
      lerp_req.go <= 1'b0;
    end else begin
      done        <= 1'b0;
      div_req.go  <= 1'b0;
      lerp_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (cmd == CMD_SAMPLE)) begin
            state <= S_KEY0;
          end
        end
        S_KEY0: begin
          if ((last == '0) || (t_q < rdata.tstamp)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (t_q < rdata.tstamp) begin
            div_req.go <= 1'b1;
            state      <= S_DIV;
          end else if (idx == last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            lerp_req.go <= 1'b1;
            state       <= S_LERP;
          end
        end
        S_LERP: begin
          if (lerp_rsp.done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          t_q  <= sample_time;
          last <= last_idx;
        end
      end
      S_KEY0: begin
        k0_x <= rdata.x;
        k0_y <= rdata.y;
        k0_z <= rdata.z;
        prev <= rdata;
        idx  <= IDX_W'(1);
        // Clamp: before the first key or a single key in use
        out_x   <= rdata.x;
        out_y   <= rdata.y;
        out_z   <= rdata.z;
        segment <= '0;
        clamped <= 1'b1;
      end
      S_SCAN: begin
        if (t_q < rdata.tstamp) begin
          nxt <= rdata;
          seg <= idx - IDX_W'(1);
        end else begin
          // Advance; at the last key, fall back to key 0
          prev    <= rdata;
          idx     <= idx + IDX_W'(1);
          out_x   <= k0_x;
          out_y   <= k0_y;
          out_z   <= k0_z;
          segment <= '0;
          clamped <= 1'b1;
        end
      end
      S_LERP: begin
        if (lerp_rsp.done) begin
          out_x   <= lx;
          out_y   <= ly;
          out_z   <= lz;
          segment <= SEG_W'(seg);
          clamped <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import klerp_pkg::*;

  localparam int TRACK_KEYS = 64;
  localparam int ITEM_GOAL  = 1500;

  typedef struct {
    logic        cmd;
    logic [5:0]  slot;
    logic [31:0] ktime;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [31:0] stime;
  } track_cmd_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  seg;
    logic        clamped;
  } track_res_t;

  class lerp_scoreboard;
    logic [31:0] key_time [TRACK_KEYS];
    logic [31:0] key_x [TRACK_KEYS];
    logic [31:0] key_y [TRACK_KEYS];
    logic [31:0] key_z [TRACK_KEYS];
    logic [6:0]  key_count;
    track_res_t  expected_q [$];
    int          errors;

    function new();
      key_count = 7'd1;
      errors = 0;
      foreach (key_time[i]) begin
        key_time[i] = '0;
        key_x[i] = '0;
        key_y[i] = '0;
        key_z[i] = '0;
      end
    endfunction

    function void set_key_count(logic [6:0] v);
      key_count = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int keys_in_use();
      if (key_count == 0) return 1;
      if (key_count > TRACK_KEYS) return TRACK_KEYS;
      return key_count;
    endfunction

    // start + floor((end - start) * f / 2^16), arithmetic shift gives the floor
    function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [15:0] f);
      longint s, d, prod;
      s = longint'($signed(a));
      d = longint'($signed(b)) - s;
      prod = d * longint'({1'b0, f});
      return 32'(s + (prod >>> 16));
    endfunction

    function track_res_t sample_at(logic [31:0] t);
      track_res_t r;
      int keys, seg;
      bit found;
      logic [31:0] dt, span;
      logic [63:0] ratio;
      logic [15:0] f;
      keys = keys_in_use();
      found = 1'b0;
      seg = 0;
      if (keys > 1 && t >= key_time[0]) begin
        for (int i = 0; i + 1 < keys; i++) begin
          if (t < key_time[i+1]) begin
            seg = i;
            found = 1'b1;
            break;
          end
        end
      end
      if (!found) begin
        r.x = key_x[0];
        r.y = key_y[0];
        r.z = key_z[0];
        r.seg = '0;
        r.clamped = 1'b1;
        return r;
      end
      dt = key_time[seg+1] - key_time[seg];
      span = t - key_time[seg];
      ratio = (dt != 0) ? ({32'd0, span} << 16) / {32'd0, dt} : 64'd0;
      f = (ratio > 64'hFFFF) ? 16'hFFFF : ratio[15:0];
      r.x = blend(key_x[seg], key_x[seg+1], f);
      r.y = blend(key_y[seg], key_y[seg+1], f);
      r.z = blend(key_z[seg], key_z[seg+1], f);
      r.seg = 6'(seg);
      r.clamped = 1'b0;
      return r;
    endfunction

    function void note_command(track_cmd_t c);
      if (c.cmd == CMD_WRITE) begin
        key_time[c.slot] = c.ktime;
        key_x[c.slot] = c.kx;
        key_y[c.slot] = c.ky;
        key_z[c.slot] = c.kz;
      end else begin
        expected_q = {expected_q, sample_at(c.stime)};
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(track_res_t got);
      track_res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: x=%h y=%h z=%h segment=%0d clamped=%b",
                 $time, got.x, got.y, got.z, got.seg, got.clamped);
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x) report("out_x", want.x, got.x);
      if (got.y !== want.y) report("out_y", want.y, got.y);
      if (got.z !== want.z) report("out_z", want.z, got.z);
      if (got.seg !== want.seg) report("segment", 32'(want.seg), 32'(got.seg));
      if (got.clamped !== want.clamped) report("clamped", 32'(want.clamped), 32'(got.clamped));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [5:0]  key_slot;
  logic [31:0] key_time;
  logic [31:0] key_x;
  logic [31:0] key_y;
  logic [31:0] key_z;
  logic [31:0] sample_time;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;
  logic        done;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [5:0]  segment;
  logic        clamped;

  lerp_scoreboard sb = new();
  int issued = 0;
  bit no_idle = 1'b0;

  keyframe_track_lerp_sampler u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .key_slot(key_slot),
    .key_time(key_time),
    .key_x(key_x),
    .key_y(key_y),
    .key_z(key_z),
    .sample_time(sample_time),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .segment(segment),
    .clamped(clamped)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // check results before noting new transactions taken at the same edge
  always @(posedge clk) begin : monitor
    track_res_t got;
    track_cmd_t seen;
    if (!rst) begin
      if (done) begin
        got.x = out_x;
        got.y = out_y;
        got.z = out_z;
        got.seg = segment;
        got.clamped = clamped;
        sb.check_result(got);
      end
      if (start && !busy) begin
        seen.cmd = cmd;
        seen.slot = key_slot;
        seen.ktime = key_time;
        seen.kx = key_x;
        seen.ky = key_y;
        seen.kz = key_z;
        seen.stime = sample_time;
        sb.note_command(seen);
      end
      if (cfg_valid && cfg_ready) sb.set_key_count(cfg_data);
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 2000) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic track_cmd_t make_write(logic [5:0] slot, logic [31:0] t,
                                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
    track_cmd_t c;
    c.cmd = CMD_WRITE;
    c.slot = slot;
    c.ktime = t;
    c.kx = x;
    c.ky = y;
    c.kz = z;
    c.stime = $urandom;
    return c;
  endfunction

  function automatic track_cmd_t make_sample(logic [31:0] t);
    track_cmd_t c;
    c.cmd = CMD_SAMPLE;
    c.slot = 6'($urandom);
    c.ktime = $urandom;
    c.kx = $urandom;
    c.ky = $urandom;
    c.kz = $urandom;
    c.stime = t;
    return c;
  endfunction

  // aim mostly inside segments and at key boundaries
  function automatic logic [31:0] pick_time(int keys);
    int k;
    logic [31:0] lo, hi;
    k = $urandom_range(0, keys - 1);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return sb.key_time[k];
      3: return sb.key_time[k] - 32'd1;
      4: return sb.key_time[k] + 32'd1;
      5: return $urandom;
      default: begin
        if (keys < 2) return $urandom;
        k = $urandom_range(0, keys - 2);
        lo = sb.key_time[k];
        hi = sb.key_time[k+1];
        if (hi <= lo) return lo;
        return lo + ($urandom % (hi - lo));
      end
    endcase
  endfunction

  task automatic issue(track_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      cmd <= 1'($urandom);
      sample_time <= $urandom;
      key_time <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= c.cmd;
    key_slot <= c.slot;
    key_time <= c.ktime;
    key_x <= c.kx;
    key_y <= c.ky;
    key_z <= c.kz;
    sample_time <= c.stime;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  // drop start, drain outstanding samples, then give the sequencer time to go idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_track_length(logic [6:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // shape 0: rising times, 1: rising with repeated times, 2: unordered
  task automatic load_track(int keys, int shape);
    logic [32:0] t;
    logic [31:0] step_max;
    logic [31:0] kt;
    case ($urandom_range(0, 3))
      0: step_max = 32'd16;
      1: step_max = 32'h0000_FFFF;
      2: step_max = 32'h0010_0000;
      default: step_max = 32'h0400_0000;
    endcase
    t = ($urandom_range(0, 2) == 0) ? {1'b0, $urandom >> 1} : 33'($urandom_range(0, 4096));
    for (int i = 0; i < keys; i++) begin
      kt = t[32] ? 32'hFFFF_FFFF : t[31:0];
      if (shape == 2) kt = $urandom;
      issue(make_write(6'(i), kt, rand_value(), rand_value(), rand_value()));
      if (!(shape == 1 && $urandom_range(0, 3) == 0))
        t = t + 33'($urandom_range(1, step_max));
    end
  endtask

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [6:0] lengths [6];
    logic [6:0] len;
    int keys, shape, phase;
    lengths = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd65};
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_WRITE;
    key_slot = '0;
    key_time = '0;
    key_x = '0;
    key_y = '0;
    key_z = '0;
    sample_time = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill every slot first so no search ever touches an unwritten entry
    for (int i = 0; i < TRACK_KEYS; i++)
      issue(make_write(6'(i), 32'(i * 16), rand_value(), rand_value(), rand_value()));

    // full-range span and opposite extreme values
    set_track_length(7'd2);
    issue(make_write(6'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0));
    issue(make_write(6'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    issue(make_sample(32'd0));
    issue(make_sample(32'd1));
    issue(make_sample(32'h7FFF_FFFF));
    issue(make_sample(32'hFFFF_FFFE));
    issue(make_sample(32'hFFFF_FFFF));
    // before the first key, and exactly on it
    issue(make_write(6'd0, 32'd100, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678));
    issue(make_sample(32'd50));
    issue(make_sample(32'd100));
    set_track_length(7'd1);
    issue(make_sample($urandom));
    set_track_length(7'd0);
    issue(make_sample($urandom));
    set_track_length(7'd127);
    issue(make_sample(32'd200));
    issue(make_sample(32'hFFFF_FFFE));
    set_track_length(7'd65);
    issue(make_sample(32'd300));
    // repeated key time, then a key out of order
    set_track_length(7'd3);
    issue(make_write(6'd0, 32'd10, 32'd0, 32'd1000, 32'hFFFF_FC18));
    issue(make_write(6'd1, 32'd10, 32'd500, 32'd0, 32'd0));
    issue(make_write(6'd2, 32'd20, 32'h8000_0000, 32'h7FFF_FFFF, 32'd7));
    issue(make_sample(32'd10));
    issue(make_sample(32'd15));
    issue(make_write(6'd1, 32'd5, 32'd500, 32'd0, 32'd0));
    issue(make_sample(32'd12));
    issue(make_write(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_5555));

    phase = 0;
    while (issued < ITEM_GOAL) begin
      if (phase < 6)
        len = lengths[phase];
      else if ($urandom_range(0, 3) == 0)
        len = 7'($urandom_range(0, 127));
      else
        len = 7'($urandom_range(2, 16));
      set_track_length(len);
      no_idle = ($urandom_range(0, 3) == 0);
      keys = sb.keys_in_use();
      shape = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
      load_track(keys, shape);
      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 9) == 0)
          issue(make_write(6'($urandom), $urandom, rand_value(), rand_value(), rand_value()));
        else
          issue(make_sample(pick_time(keys)));
      end
      phase++;
    end

    settle();
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/klerp_pkg.sv
hdl/klerp_store.sv
hdl/klerp_div.sv
hdl/klerp_lerp.sv
hdl/keyframe_track_lerp_sampler.sv
tb/tb_top.sv
